### hdl/xkc_pkg.sv
// Package for the repeating-key XOR cipher with printable escapes.
// Holds the shared types, register indexes and character constants.
// No dependencies.
package xkc_pkg;

  localparam int KeyBytes   = 16;
  localparam int KeyPosW    = $clog2(KeyBytes);
  localparam int KeyLenW    = 5;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int ApbAddrW   = 5;
  localparam int ApbDataW   = 64;

  localparam logic [8:0] PrintLo    = 9'd33;
  localparam logic [8:0] PrintHi    = 9'd126;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChStar     = 8'h2A;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [3:0] DecadeLast = 4'd9;

  localparam logic DirEncrypt = 1'b0;

  typedef enum logic [1:0] {
    RegDirection = 2'd0,
    RegKeyLength = 2'd1,
    RegKeyLow    = 2'd2,
    RegKeyHigh   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                             direction;
    logic [KeyLenW-1:0]               key_length;
    logic [KeyBytes-1:0][7:0]         key_bytes;
  } cfg_t;

  // One queued job: a plain byte, or a 9-bit value to send as an escape.
  typedef struct packed {
    logic       esc;
    logic [8:0] value;
  } job_t;

endpackage

### hdl/xkc_if.sv
// Stream channel interfaces for the cipher core: input and result beats.
// Depends on nothing.
interface xkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;
  logic       message_end;

  modport source (output valid, data_byte, message_start, message_end, input ready);
  modport sink   (input valid, data_byte, message_start, message_end, output ready);
endinterface

interface xkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

### hdl/xkc_front.sv
// Front end: accepts input beats, tracks key/decade positions and escape parse,
// classifies each beat into a queued job. Depends on xkc_pkg and xkc_if.
module xkc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xkc_pkg::cfg_t   cfg_i,
  xkc_in_if.sink          in_ch,
  input  logic            full_i,
  output logic            push_o,
  output xkc_pkg::job_t   job_o
);

  logic [xkc_pkg::KeyPosW-1:0] kp_q, kp_d, kp, kp_adv;
  logic [3:0]                  dp_q, dp_d, dp, dp_adv;
  logic                        ea_q, ea_d, ea;
  logic [7:0]                  ev_q, ev_d, ev;
  logic [8:0]                  code, v;
  logic [xkc_pkg::KeyLenW-1:0] len_eff, kp_inc;
  logic [7:0]                  b, dec_byte;
  logic                        emit, adv, accept;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    kp = in_ch.message_start ? '0 : kp_q;
    dp = in_ch.message_start ? '0 : dp_q;
    ea = in_ch.message_start ? 1'b0 : ea_q;
    ev = in_ch.message_start ? '0 : ev_q;

    code = {1'b0, cfg_i.key_bytes[kp]} + {5'd0, dp};

    if (cfg_i.key_length == '0) begin
      len_eff = xkc_pkg::KeyLenW'(1);
    end else if (cfg_i.key_length > xkc_pkg::KeyLenW'(xkc_pkg::KeyBytes)) begin
      len_eff = xkc_pkg::KeyLenW'(xkc_pkg::KeyBytes);
    end else begin
      len_eff = cfg_i.key_length;
    end
    kp_inc = {1'b0, kp} + xkc_pkg::KeyLenW'(1);
    kp_adv = (kp_inc >= len_eff) ? '0 : kp_inc[xkc_pkg::KeyPosW-1:0];
    dp_adv = (dp == xkc_pkg::DecadeLast) ? '0 : dp + 4'd1;

    emit     = 1'b0;
    adv      = 1'b0;
    ea_d     = ea;
    ev_d     = ev;
    v        = {1'b0, b} ^ code;
    dec_byte = '0;
    job_o    = '0;

    if (cfg_i.direction == xkc_pkg::DirEncrypt) begin
      emit        = 1'b1;
      adv         = 1'b1;
      job_o.esc   = !(v >= xkc_pkg::PrintLo && v <= xkc_pkg::PrintHi);
      job_o.value = v;
    end else begin
      if (ea) begin
        if (b == xkc_pkg::ChStar) begin
          emit     = 1'b1;
          adv      = 1'b1;
          dec_byte = ev ^ code[7:0];
          ea_d     = 1'b0;
          ev_d     = '0;
        end else begin
          ev_d = (ev << 3) + (ev << 1) + b - xkc_pkg::ChZero;
        end
      end else if (b == xkc_pkg::ChSpace) begin
        ea_d = 1'b1;
        ev_d = '0;
      end else begin
        emit     = 1'b1;
        adv      = 1'b1;
        dec_byte = b ^ code[7:0];
      end
      // flush an unterminated escape on the final byte
      if (in_ch.message_end && ea_d) begin
        emit     = 1'b1;
        adv      = 1'b1;
        dec_byte = ev_d ^ code[7:0];
        ea_d     = 1'b0;
        ev_d     = '0;
      end
      job_o.esc   = 1'b0;
      job_o.value = {1'b0, dec_byte};
    end

    kp_d = adv ? kp_adv : kp;
    dp_d = adv ? dp_adv : dp;
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      dp_q <= '0;
      ea_q <= 1'b0;
      ev_q <= '0;
    end else if (accept) begin
      kp_q <= kp_d;
      dp_q <= dp_d;
      ea_q <= ea_d;
      ev_q <= ev_d;
    end
  end

endmodule

### hdl/xkc_fifo.sv
// Short job queue between the front end and the output sequencer.
// Depends on xkc_pkg.
module xkc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xkc_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output xkc_pkg::job_t job_o
);

  xkc_pkg::job_t                 mem_q [xkc_pkg::QueueDepth];
  logic [xkc_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [xkc_pkg::QueueCntW-1:0] cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == xkc_pkg::QueueCntW'(xkc_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + xkc_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + xkc_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + xkc_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - xkc_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

### hdl/xkc_back.sv
// Output sequencer: takes jobs from the queue and drives result beats,
// expanding escapes into space, decimal digits and asterisk. Depends on xkc_pkg, xkc_if.
module xkc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  xkc_pkg::job_t job_i,
  output logic          pop_o,
  xkc_out_if.source     out_ch
);

  typedef enum logic [5:0] {
    StDirect = 6'b000001,
    StSpace  = 6'b000010,
    StHund   = 6'b000100,
    StTens   = 6'b001000,
    StOnes   = 6'b010000,
    StStar   = 6'b100000
  } step_e;

  localparam logic [8:0] Hundred = 9'd100;
  localparam logic [8:0] Ten     = 9'd10;

  step_e      step_q, step_d;
  logic       busy_q, busy_d;
  logic [8:0] val_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q, cur_byte;
  logic       out_last_q, cur_last;
  logic       emit;
  logic [2:0] hund;
  logic [6:0] rem;
  logic [3:0] tens, ones;

  always_comb begin
    hund = '0;
    for (int k = 1; k <= 5; k++) begin
      if (val_q >= 9'(100 * k)) hund = 3'(k);
    end
    rem  = 7'(val_q - {6'd0, hund} * Hundred);
    tens = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= 7'(10 * k)) tens = 4'(k);
    end
    ones = 4'(rem - 7'(tens) * 7'd10);
  end

  assign emit  = busy_q && (!out_valid_q || out_ch.ready);
  assign pop_o = valid_i && (!busy_q || (emit && cur_last));

  always_comb begin
    cur_byte = '0;
    cur_last = 1'b0;
    step_d   = step_q;
    unique case (step_q)
      StDirect: begin
        cur_byte = val_q[7:0];
        cur_last = 1'b1;
      end
      StSpace: begin
        cur_byte = xkc_pkg::ChSpace;
        if (val_q >= Hundred) begin
          step_d = StHund;
        end else if (val_q >= Ten) begin
          step_d = StTens;
        end else begin
          step_d = StOnes;
        end
      end
      StHund: begin
        cur_byte = xkc_pkg::ChZero + {5'd0, hund};
        step_d   = StTens;
      end
      StTens: begin
        cur_byte = xkc_pkg::ChZero + {4'd0, tens};
        step_d   = StOnes;
      end
      StOnes: begin
        cur_byte = xkc_pkg::ChZero + {4'd0, ones};
        step_d   = StStar;
      end
      StStar: begin
        cur_byte = xkc_pkg::ChStar;
        cur_last = 1'b1;
      end
      default: begin
        cur_byte = '0;
        cur_last = 1'b1;
      end
    endcase

    busy_d = busy_q;
    if (emit && cur_last) begin
      busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = job_i.esc ? StSpace : StDirect;
    end else if (!emit) begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      val_q <= job_i.value;
    end
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StDirect;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.run_last = out_last_q;

endmodule

### hdl/xor_key_cipher_printable_escape_core.sv
// Top level of the repeating-key XOR cipher with printable escapes.
// Depends on xkc_pkg, xkc_if, xkc_front, xkc_fifo, xkc_back.
//
// The core accepts one input byte per cycle while its two-entry job queue has
// room. In encrypt mode a printable result (33..126) is one output beat, so such
// streams run at one byte per cycle while the output is ready; any other result
// is sent as a space, one to three decimal digits and an asterisk, which busies
// the output sequencer and stalls input once the queue fills. Decrypt mode gives
// at most one beat per input byte, none for bytes that open or extend an escape
// before message end, and keeps one byte per cycle while the output is ready.
// Configuration (APB, 64-bit data, register i at byte address 8*i) is to be
// written by the user only while the core is idle; the core does not enforce it.
module xor_key_cipher_printable_escape_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  xkc_in_if.sink                        in_ch,
  xkc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xkc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [xkc_pkg::ApbDataW-1:0]  pwdata,
  output logic [xkc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  logic                         dir_q;
  logic [xkc_pkg::KeyLenW-1:0]  klen_q;
  logic [63:0]                  klo_q, khi_q;
  xkc_pkg::cfg_t                cfg;
  xkc_pkg::reg_idx_e            reg_idx;
  logic                         cfg_wr;

  logic                         fifo_push, fifo_full, fifo_valid, back_pop;
  xkc_pkg::job_t                push_job, head_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = xkc_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      klen_q <= xkc_pkg::KeyLenW'(1);
      klo_q  <= '0;
      khi_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        xkc_pkg::RegDirection: dir_q  <= pwdata[0];
        xkc_pkg::RegKeyLength: klen_q <= pwdata[xkc_pkg::KeyLenW-1:0];
        xkc_pkg::RegKeyLow:    klo_q  <= pwdata;
        xkc_pkg::RegKeyHigh:   khi_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      xkc_pkg::RegDirection: prdata = {63'd0, dir_q};
      xkc_pkg::RegKeyLength: prdata = {59'd0, klen_q};
      xkc_pkg::RegKeyLow:    prdata = klo_q;
      xkc_pkg::RegKeyHigh:   prdata = khi_q;
      default:               prdata = '0;
    endcase
  end

  assign cfg.direction  = dir_q;
  assign cfg.key_length = klen_q;
  assign cfg.key_bytes  = {khi_q, klo_q};

  xkc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .full_i (fifo_full),
    .push_o (fifo_push),
    .job_o  (push_job)
  );

  xkc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .job_i   (push_job),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (back_pop),
    .job_o   (head_job)
  );

  xkc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .job_i   (head_job),
    .pop_o   (back_pop),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("job pushed into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> fifo_valid)
    else $error("job popped from empty queue");

  a_encrypt_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && cfg.direction == xkc_pkg::DirEncrypt) |-> fifo_push)
    else $error("encrypt beat produced no job");

endmodule
